FILE: rtl/core/tta_pkg.sv
// ----------------------------------------------------------------------------
// tta_pkg: shared types and constants of the TIM to ARGB decoder
// Holds the result descriptor, the error and depth codes and color expansion.
// ----------------------------------------------------------------------------
package tta_pkg;

    // Default sizes of the palette store and the largest image
    localparam int TTA_PALETTE_ENTRIES = 256;
    localparam int TTA_MAX_COLUMNS     = 4096;
    localparam int TTA_MAX_ROWS        = 512;

    // Field widths fixed by the result format
    localparam int PAL_IDX_W = 8;
    localparam int COL_OUT_W = 12;
    localparam int ROW_OUT_W = 9;

    // File header constants
    localparam logic [31:0] TIM_MAGIC = 32'h0000_0010;
    localparam int          CLUT_HDR_BYTES = 12;
    localparam int          PIX_HDR_BYTES  = 12;

    // Error codes carried with each result
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_MAGIC      = 3'd1,
        ERR_MODE       = 3'd2,
        ERR_NO_PALETTE = 3'd3,
        ERR_TOO_LARGE  = 3'd4
    } err_code_t;

    // Pixel depth modes from the type word
    typedef enum logic [1:0] {
        DEPTH_IDX4  = 2'd0,
        DEPTH_IDX8  = 2'd1,
        DEPTH_RGB15 = 2'd2,
        DEPTH_RGB24 = 2'd3
    } depth_t;

    // One pending result: either a palette lookup or a finished color
    typedef struct packed {
        logic                 use_pal;
        logic [PAL_IDX_W-1:0] pal_idx;
        logic [31:0]          argb;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 done;
        err_code_t            err;
        logic                 last;
    } res_desc_t;

    // Expand a 15-bit color with mask bit to ARGB
    function automatic logic [31:0] color15(input logic [15:0] n);
        logic [7:0] alpha;
        alpha = n[15] ? 8'hFF : 8'h00;
        return {alpha, n[4:0], 3'b000, n[9:5], 3'b000, n[14:10], 3'b000};
    endfunction

endpackage

FILE: rtl/core/tim_texture_to_argb_unit.sv
// ----------------------------------------------------------------------------
// tim_texture_to_argb_unit: byte-serial TIM image decoder with ARGB output
// Throughput: one byte per cycle while the output is not stalled; in 4-bit
// mode a byte gives two results (one result per cycle); palette bytes stall
// while earlier lookups are queued.
// Reset clears the parser and pipeline at once; the palette is not cleared.
// ----------------------------------------------------------------------------
module tim_texture_to_argb_unit #(
    parameter int PALETTE_ENTRIES = tta_pkg::TTA_PALETTE_ENTRIES,
    parameter int MAX_COLUMNS     = tta_pkg::TTA_MAX_COLUMNS,
    parameter int MAX_ROWS        = tta_pkg::TTA_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] pixel_argb, [43:32] pixel_col,
                                   // [52:44] pixel_row, [55:53] zero
    output logic [3:0]  m_tuser,   // [0] image_done, [3:1] error_code
    output logic        m_tlast    // last_of_run
);
    import tta_pkg::*;

    localparam int PA_W  = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(2 * PALETTE_ENTRIES) + 1;
    localparam int CC_W  = $clog2(MAX_COLUMNS);
    localparam int CW_W  = $clog2(MAX_COLUMNS + 1);
    localparam int RC_W  = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CLUT_HDR,
        PH_CLUT_DATA,
        PH_PIX_HDR,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic [31:0]       field_reg, field_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    depth_t            depth_reg, depth_next;
    logic [CW_W-1:0]   img_w_reg, img_w_next;
    logic [RC_W-1:0]   img_h_reg, img_h_next;
    logic [CC_W-1:0]   col_reg, col_next;
    logic [RC_W-1:0]   row_reg, row_next;
    logic [15:0]       pend_reg, pend_next;
    logic [1:0]        bp_reg, bp_next;

    // Values as seen by the current byte, after a file restart
    phase_t            e_phase;
    logic [31:0]       e_field;
    logic [CNT_W-1:0]  e_cnt;
    logic [CC_W-1:0]   e_col;
    logic [RC_W-1:0]   e_row;
    logic [15:0]       e_pend;
    logic [1:0]        e_bp;

    logic              in_accept;
    logic [CNT_W-1:0]  cnt_inc;
    logic [31:0]       field_or;
    logic [31:0]       pix_hdr;
    logic [15:0]       hdr_w;
    logic [15:0]       hdr_h;
    logic [17:0]       width_px;

    // Raster position after one and two pixels
    logic [CW_W-1:0]   c1_sum, c2_sum;
    logic              wrap1, wrap2;
    logic [CC_W-1:0]   col1, col2;
    logic [RC_W-1:0]   row1, row2;
    logic              done1, done2;

    // Results of this byte
    res_desc_t         d0, d1;
    logic [1:0]        n_res;

    // Palette store
    logic [15:0]       pal_mem [PALETTE_ENTRIES];
    logic              pal_we;
    logic [PA_W-1:0]   pal_waddr;
    logic [15:0]       pal_wdata;
    logic              pal_re;
    logic [PA_W-1:0]   pal_raddr;
    logic [15:0]       pal_rdata_reg;

    // Result queue
    res_desc_t         job_mem [4];
    logic [1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [2:0]        job_cnt_reg, job_cnt_next;
    res_desc_t         job_head;
    logic              issue;

    // Palette read stage and result register
    logic              r_valid_reg;
    res_desc_t         r_desc_reg;
    logic              out_free;
    logic              m_tvalid_reg;
    logic [31:0]       out_argb_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic              out_done_reg;
    err_code_t         out_err_reg;
    logic              out_last_reg;

    // Hold palette bytes while queued lookups have not yet read the palette
    assign s_tready  = (job_cnt_reg <= 3'd1)
                       && !(phase_reg == PH_CLUT_DATA && job_cnt_reg != 3'd0);
    assign in_accept = s_tvalid && s_tready;

    // Restart the parse on a file start
    always_comb begin
        e_phase = phase_reg;
        e_field = field_reg;
        e_cnt   = cnt_reg;
        e_col   = col_reg;
        e_row   = row_reg;
        e_pend  = pend_reg;
        e_bp    = bp_reg;
        if (s_tuser) begin
            e_phase = PH_HEADER;
            e_field = '0;
            e_cnt   = '0;
            e_col   = '0;
            e_row   = '0;
            e_pend  = '0;
            e_bp    = '0;
        end
    end

    assign cnt_inc  = (&e_cnt) ? e_cnt : e_cnt + CNT_W'(1);
    assign field_or = e_field | (32'(s_tdata) << {e_cnt[1:0], 3'b000});
    assign pix_hdr  = field_or;
    assign hdr_w    = pix_hdr[15:0];
    assign hdr_h    = pix_hdr[31:16];

    // Pixel width of the image from the halfword count
    always_comb begin
        case (depth_reg)
            DEPTH_IDX4:  width_px = {hdr_w, 2'b00};
            DEPTH_IDX8:  width_px = {1'b0, hdr_w, 1'b0};
            DEPTH_RGB15: width_px = {2'b00, hdr_w};
            DEPTH_RGB24: width_px = 18'(hdr_w) + 18'(hdr_w[15:1]);
            default:     width_px = {2'b00, hdr_w};
        endcase
    end

    // Advance the raster position by one and by two pixels
    assign c1_sum = CW_W'(e_col) + CW_W'(1);
    assign wrap1  = (c1_sum >= img_w_reg);
    assign col1   = wrap1 ? '0 : CC_W'(c1_sum);
    assign row1   = e_row + RC_W'(wrap1);
    assign done1  = (row1 >= img_h_reg);
    assign c2_sum = CW_W'(col1) + CW_W'(1);
    assign wrap2  = (c2_sum >= img_w_reg);
    assign col2   = wrap2 ? '0 : CC_W'(c2_sum);
    assign row2   = row1 + RC_W'(wrap2);
    assign done2  = (row2 >= img_h_reg);

    // Parse one byte
    always_comb begin
        phase_next = phase_reg;
        field_next = field_reg;
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        img_w_next = img_w_reg;
        img_h_next = img_h_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        bp_next    = bp_reg;
        d0         = '0;
        d1         = '0;
        n_res      = 2'd0;
        pal_we     = 1'b0;
        pal_waddr  = PA_W'(e_cnt[CNT_W-1:1]);
        pal_wdata  = {s_tdata, e_pend[7:0]};
        if (in_accept) begin
            phase_next = e_phase;
            field_next = e_field;
            cnt_next   = e_cnt;
            col_next   = e_col;
            row_next   = e_row;
            pend_next  = e_pend;
            bp_next    = e_bp;
            case (e_phase)
                PH_HEADER: begin
                    field_next = field_or;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == CNT_W'(4)) begin
                        if (field_or != TIM_MAGIC) begin
                            d0.err     = ERR_MAGIC;
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            field_next = '0;
                        end
                    end else if (cnt_inc == CNT_W'(8)) begin
                        field_next = '0;
                        cnt_next   = '0;
                        if (field_or[2]) begin
                            d0.err     = ERR_MODE;
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                        end else if (!field_or[1] && field_or[31:3] == '0) begin
                            d0.err     = ERR_NO_PALETTE;
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            depth_next = depth_t'(field_or[1:0]);
                            phase_next = (field_or[31:3] != '0) ? PH_CLUT_HDR
                                                                 : PH_PIX_HDR;
                        end
                    end
                end
                PH_CLUT_HDR: begin
                    if (e_cnt < CNT_W'(4)) begin
                        field_next = field_or;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == CNT_W'(CLUT_HDR_BYTES)) begin
                        cnt_next = '0;
                        if (field_next > 32'(CLUT_HDR_BYTES)) begin
                            field_next = field_next - 32'(CLUT_HDR_BYTES);
                            phase_next = PH_CLUT_DATA;
                        end else begin
                            field_next = '0;
                            phase_next = PH_PIX_HDR;
                        end
                    end
                end
                PH_CLUT_DATA: begin
                    // Odd byte completes a halfword; store it while in range
                    if (e_cnt[0]) begin
                        pal_we = ((e_cnt >> 1) < CNT_W'(PALETTE_ENTRIES));
                    end else begin
                        pend_next = {8'h00, s_tdata};
                    end
                    cnt_next   = cnt_inc;
                    field_next = e_field - 32'd1;
                    if (field_next == '0) begin
                        cnt_next   = '0;
                        phase_next = PH_PIX_HDR;
                    end
                end
                PH_PIX_HDR: begin
                    if (e_cnt >= CNT_W'(8)) begin
                        field_next = field_or;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == CNT_W'(PIX_HDR_BYTES)) begin
                        field_next = '0;
                        cnt_next   = '0;
                        if (width_px > 18'(MAX_COLUMNS) || hdr_h > 16'(MAX_ROWS)) begin
                            d0.err     = ERR_TOO_LARGE;
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                        end else if (width_px == '0 || hdr_h == '0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            img_w_next = CW_W'(width_px);
                            img_h_next = RC_W'(hdr_h);
                            col_next   = '0;
                            row_next   = '0;
                            bp_next    = '0;
                            pend_next  = '0;
                            phase_next = PH_PIXELS;
                        end
                    end
                end
                PH_PIXELS: begin
                    d0.col  = COL_OUT_W'(e_col);
                    d0.row  = ROW_OUT_W'(e_row);
                    d0.done = done1;
                    d1.col  = COL_OUT_W'(col1);
                    d1.row  = ROW_OUT_W'(row1);
                    d1.done = done2;
                    case (depth_reg)
                        DEPTH_IDX4: begin
                            d0.pal_idx = {4'h0, s_tdata[3:0]};
                            d0.use_pal = (9'(s_tdata[3:0]) < 9'(PALETTE_ENTRIES));
                            d1.pal_idx = {4'h0, s_tdata[7:4]};
                            d1.use_pal = (9'(s_tdata[7:4]) < 9'(PALETTE_ENTRIES));
                            if (done1) begin
                                n_res = 2'd1;
                            end else begin
                                n_res = 2'd2;
                            end
                        end
                        DEPTH_IDX8: begin
                            d0.pal_idx = s_tdata;
                            d0.use_pal = (9'(s_tdata) < 9'(PALETTE_ENTRIES));
                            n_res      = 2'd1;
                        end
                        DEPTH_RGB15: begin
                            if (e_bp == 2'd0) begin
                                pend_next = {8'h00, s_tdata};
                                bp_next   = 2'd1;
                            end else begin
                                bp_next = 2'd0;
                                d0.argb = color15({s_tdata, e_pend[7:0]});
                                n_res   = 2'd1;
                            end
                        end
                        DEPTH_RGB24: begin
                            if (e_bp == 2'd0) begin
                                pend_next = {8'h00, s_tdata};
                                bp_next   = 2'd1;
                            end else if (e_bp == 2'd1) begin
                                pend_next = {s_tdata, e_pend[7:0]};
                                bp_next   = 2'd2;
                            end else begin
                                bp_next = 2'd0;
                                d0.argb = {8'hFF, e_pend[7:0], e_pend[15:8], s_tdata};
                                n_res   = 2'd1;
                            end
                        end
                        default: begin
                            n_res = 2'd0;
                        end
                    endcase
                    // Move the raster position past the emitted pixels
                    if (n_res == 2'd2) begin
                        col_next = col2;
                        row_next = row2;
                        if (done2) begin
                            phase_next = PH_IDLE;
                        end
                    end else if (n_res == 2'd1) begin
                        col_next = col1;
                        row_next = row1;
                        if (done1) begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: begin
                    phase_next = e_phase;
                end
            endcase
            // Mark the final result of this byte
            if (n_res == 2'd2) begin
                d1.last = 1'b1;
            end else begin
                d0.last = 1'b1;
            end
        end
    end

    // Hold the parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            field_reg <= '0;
            cnt_reg   <= '0;
            depth_reg <= DEPTH_IDX4;
            img_w_reg <= '0;
            img_h_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            bp_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
            img_w_reg <= img_w_next;
            img_h_reg <= img_h_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            bp_reg    <= bp_next;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        if (pal_re) begin
            pal_rdata_reg <= pal_mem[pal_raddr];
        end
    end

    // Queue: take up to two results per byte, issue one per cycle unless stalled
    assign job_head  = job_mem[rd_ptr_reg];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign issue     = (job_cnt_reg != 3'd0) && (!r_valid_reg || out_free);
    assign pal_re    = issue && job_head.use_pal;
    assign pal_raddr = PA_W'(job_head.pal_idx);

    always_comb begin
        job_cnt_next = job_cnt_reg + (in_accept ? 3'(n_res) : 3'd0) - 3'(issue);
    end

    always_ff @(posedge aclk) begin
        if (in_accept && n_res != 2'd0) begin
            job_mem[wr_ptr_reg] <= d0;
        end
        if (in_accept && n_res == 2'd2) begin
            job_mem[wr_ptr_reg + 2'd1] <= d1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            job_cnt_reg <= '0;
        end else begin
            if (in_accept) begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (issue) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            job_cnt_reg <= job_cnt_next;
        end
    end

    // Read stage: descriptor waits beside the palette read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (issue) begin
            r_valid_reg <= 1'b1;
        end else if (out_free) begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            r_desc_reg <= job_head;
        end
    end

    // Result register: load when empty or taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && r_valid_reg) begin
            out_argb_reg <= r_desc_reg.use_pal ? color15(pal_rdata_reg) : r_desc_reg.argb;
            out_col_reg  <= r_desc_reg.col;
            out_row_reg  <= r_desc_reg.row;
            out_done_reg <= r_desc_reg.done;
            out_err_reg  <= r_desc_reg.err;
            out_last_reg <= r_desc_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_row_reg, out_col_reg, out_argb_reg};
    assign m_tuser  = {out_err_reg, out_done_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/tta_checker.sv
// ----------------------------------------------------------------------------
// tta_checker: port-level checks of the TIM to ARGB decoder
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module tta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result transaction
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Drop the result channel during reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Error results carry no pixel and end their run
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:1] != 3'd0 |->
            m_tdata[52:0] == '0 && !m_tuser[0] && m_tlast)
        else $error("malformed error result");

    // The final pixel of an image is the last result of its byte
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tuser[3:1] == 3'd0)
        else $error("image done without run end");

endmodule

bind tim_texture_to_argb_unit tta_checker u_tta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: verif/tim_argb_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tim_argb_tb_pkg: decode predictor and result scoreboard for the TIM decoder
// Parses the byte stream the same way the decoder does. Each byte that the
// decoder accepts queues the ARGB pixels or error reports it should produce.
// Each result the decoder sends is then checked against the oldest entry.
// ----------------------------------------------------------------------------
package tim_argb_tb_pkg;

    import tta_pkg::*;

    // One result as seen on the master side
    typedef struct packed {
        logic [31:0] argb;
        logic [11:0] col;
        logic [8:0]  row;
        logic        done;
        err_code_t   err;
        logic        last;
    } argb_result_t;

    // Where the parser stands within a file
    typedef enum logic [2:0] {
        TP_HEADER,
        TP_CLUT_HDR,
        TP_CLUT_DATA,
        TP_PIX_HDR,
        TP_PIXELS,
        TP_IDLE
    } tim_phase_t;

    class tim_pixel_scoreboard;

        argb_result_t expected_pixels[$];
        argb_result_t step_out[$];

        tim_phase_t   phase;
        logic [31:0]  field_acc;
        int unsigned  byte_idx;
        depth_t       depth;
        bit           pal_present;
        logic [15:0]  palette [TTA_PALETTE_ENTRIES];
        bit           pal_written [TTA_PALETTE_ENTRIES];
        int unsigned  img_cols;
        int unsigned  img_rows;
        int unsigned  col_pos;
        int unsigned  row_pos;
        logic [15:0]  held;
        int unsigned  pix_phase;

        int unsigned  fail_count;
        int unsigned  result_count;
        int unsigned  image_count;
        int unsigned  error_results;
        int unsigned  bytes_noted;

        function new();
            restart();
            depth       = DEPTH_IDX4;
            pal_present = 1'b0;
            img_cols    = 0;
            img_rows    = 0;
            foreach (pal_written[i]) pal_written[i] = 1'b0;
        endfunction

        // Return to the start of a file header
        function void restart();
            phase     = TP_HEADER;
            field_acc = '0;
            byte_idx  = 0;
            col_pos   = 0;
            row_pos   = 0;
            held      = '0;
            pix_phase = 0;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // 5-bit channels scaled by eight, top bit selects full alpha
        function logic [31:0] expand15(logic [15:0] n);
            logic [7:0] alpha;
            alpha = n[15] ? 8'hFF : 8'h00;
            return {alpha, n[4:0], 3'd0, n[9:5], 3'd0, n[14:10], 3'd0};
        endfunction

        function logic [31:0] lookup(int unsigned idx);
            if (idx >= TTA_PALETTE_ENTRIES) return expand15(16'h0000);
            if (!pal_written[idx]) begin
                $error("palette entry %0d read before it was loaded", idx);
                fail_count++;
            end
            return expand15(palette[idx]);
        endfunction

        function void add_result(logic [31:0] argb, int unsigned col, int unsigned row,
                                 bit done, err_code_t err);
            argb_result_t r;
            r.argb = argb;
            r.col  = 12'(col);
            r.row  = 9'(row);
            r.done = done;
            r.err  = err;
            r.last = 1'b0;
            if (err != ERR_NONE) error_results++;
            if (done) image_count++;
            step_out.push_back(r);
        endfunction

        // Report a header error and ignore bytes until the next file start
        function void abort(err_code_t err);
            add_result('0, 0, 0, 1'b0, err);
            phase = TP_IDLE;
        endfunction

        // Emit one pixel at the current position and advance the raster
        function void put_pixel(logic [31:0] argb);
            int unsigned c;
            int unsigned r;
            bit          done;
            c = col_pos;
            r = row_pos;
            col_pos++;
            if (col_pos >= img_cols) begin
                col_pos = 0;
                row_pos++;
            end
            done = (row_pos >= img_rows);
            if (done) phase = TP_IDLE;
            add_result(argb, c, r, done, ERR_NONE);
        endfunction

        // Advance the parse by one accepted byte and queue what it produces
        function void note_byte(logic [7:0] b, logic start);
            logic [2:0]   mode;
            bit           pal;
            int unsigned  w;
            int unsigned  h;
            int unsigned  cols;
            argb_result_t r;
            bytes_noted++;
            step_out.delete();
            if (start) restart();
            case (phase)
                TP_HEADER: begin
                    field_acc |= {24'd0, b} << (8 * (byte_idx % 4));
                    byte_idx++;
                    if (byte_idx == 4) begin
                        if (field_acc != TIM_MAGIC) abort(ERR_MAGIC);
                        else field_acc = '0;
                    end else if (byte_idx == 8) begin
                        mode      = field_acc[2:0];
                        pal       = (field_acc[31:3] != 0);
                        field_acc = '0;
                        byte_idx  = 0;
                        if (mode > 3'(DEPTH_RGB24)) begin
                            abort(ERR_MODE);
                        end else if (mode < 3'(DEPTH_RGB15) && !pal) begin
                            abort(ERR_NO_PALETTE);
                        end else begin
                            depth       = depth_t'(mode[1:0]);
                            pal_present = pal;
                            phase       = pal ? TP_CLUT_HDR : TP_PIX_HDR;
                        end
                    end
                end
                TP_CLUT_HDR: begin
                    // only the size word matters; placement bytes are skipped
                    if (byte_idx < 4) field_acc |= {24'd0, b} << (8 * byte_idx);
                    byte_idx++;
                    if (byte_idx == CLUT_HDR_BYTES) begin
                        byte_idx = 0;
                        if (field_acc > CLUT_HDR_BYTES) begin
                            field_acc -= CLUT_HDR_BYTES;
                            phase = TP_CLUT_DATA;
                        end else begin
                            field_acc = '0;
                            phase = TP_PIX_HDR;
                        end
                    end
                end
                TP_CLUT_DATA: begin
                    // store halfwords that fit, drop the overflow
                    if (byte_idx % 2 == 1) begin
                        if (byte_idx / 2 < TTA_PALETTE_ENTRIES) begin
                            palette[byte_idx / 2]     = {b, held[7:0]};
                            pal_written[byte_idx / 2] = 1'b1;
                        end
                    end else begin
                        held = {8'd0, b};
                    end
                    byte_idx++;
                    field_acc--;
                    if (field_acc == 0) begin
                        byte_idx = 0;
                        phase = TP_PIX_HDR;
                    end
                end
                TP_PIX_HDR: begin
                    if (byte_idx >= 8) field_acc |= {24'd0, b} << (8 * (byte_idx - 8));
                    byte_idx++;
                    if (byte_idx == PIX_HDR_BYTES) begin
                        w = field_acc[15:0];
                        h = field_acc[31:16];
                        case (depth)
                            DEPTH_IDX4:  cols = w * 4;
                            DEPTH_IDX8:  cols = w * 2;
                            DEPTH_RGB15: cols = w;
                            default:     cols = (w * 3) / 2;
                        endcase
                        field_acc = '0;
                        byte_idx  = 0;
                        if (cols > TTA_MAX_COLUMNS || h > TTA_MAX_ROWS) begin
                            abort(ERR_TOO_LARGE);
                        end else if (cols == 0 || h == 0) begin
                            phase = TP_IDLE;
                        end else begin
                            img_cols  = cols;
                            img_rows  = h;
                            col_pos   = 0;
                            row_pos   = 0;
                            pix_phase = 0;
                            held      = '0;
                            phase     = TP_PIXELS;
                        end
                    end
                end
                TP_PIXELS: begin
                    case (depth)
                        DEPTH_IDX4: begin
                            put_pixel(lookup(b[3:0]));
                            if (phase == TP_PIXELS) put_pixel(lookup(b[7:4]));
                        end
                        DEPTH_IDX8: put_pixel(lookup(b));
                        DEPTH_RGB15: begin
                            if (pix_phase == 0) begin
                                held      = {8'd0, b};
                                pix_phase = 1;
                            end else begin
                                pix_phase = 0;
                                put_pixel(expand15({b, held[7:0]}));
                            end
                        end
                        default: begin
                            // bytes arrive as red, green, blue
                            if (pix_phase == 0) begin
                                held      = {8'd0, b};
                                pix_phase = 1;
                            end else if (pix_phase == 1) begin
                                held      = {b, held[7:0]};
                                pix_phase = 2;
                            end else begin
                                pix_phase = 0;
                                put_pixel({8'hFF, held[7:0], held[15:8], b});
                            end
                        end
                    endcase
                end
                default: ;
            endcase
            // flag the final result of this byte and queue them all
            if (step_out.size() > 0) begin
                r = step_out[step_out.size() - 1];
                r.last = 1'b1;
                step_out[step_out.size() - 1] = r;
                foreach (step_out[i]) expected_pixels.push_back(step_out[i]);
            end
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        endfunction

        // Compare one result from the decoder with the oldest prediction
        function void check_output(argb_result_t got, logic [2:0] pad);
            argb_result_t want;
            result_count++;
            if (expected_pixels.size() == 0) begin
                $error("result with nothing expected: argb 0x%0h col %0d row %0d err %0d",
                       got.argb, got.col, got.row, got.err);
                fail_count++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.argb !== want.argb) mismatch("pixel_argb", want.argb, got.argb);
            if (got.col !== want.col) mismatch("pixel_col", 32'(want.col), 32'(got.col));
            if (got.row !== want.row) mismatch("pixel_row", 32'(want.row), 32'(got.row));
            if (got.done !== want.done) mismatch("image_done", 32'(want.done), 32'(got.done));
            if (got.err !== want.err) mismatch("error_code", 32'(want.err), 32'(got.err));
            if (got.last !== want.last) mismatch("last_of_run", 32'(want.last), 32'(got.last));
            if (pad !== 3'd0) mismatch("tdata_pad", 32'd0, 32'(pad));
        endfunction

    endclass

endpackage

FILE: verif/tb_tim_texture_to_argb_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tim_texture_to_argb_unit: self-checking regression of the TIM decoder
// Feeds hand-built TIM files (all depths, header errors, empty, oversize and
// limit-size images, broken files), then random files and noise, with random
// gaps on both sides and one long output stall. Every result is checked.
// ----------------------------------------------------------------------------
module tb_tim_texture_to_argb_unit;

    import tta_pkg::*;
    import tim_argb_tb_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_BYTES = 120;
    localparam logic [31:0] PAL_FLAG     = 32'h0000_0008;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    tim_pixel_scoreboard sb;

    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_req     = 1'b0;
    int unsigned bytes_sent   = 0;
    int unsigned cycle_count  = 0;

    tim_texture_to_argb_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tim_texture_to_argb_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Pixel data length of a well-formed image
    function automatic int unsigned needed_bytes(int unsigned mode, int unsigned w,
                                                 int unsigned h);
        if (mode == DEPTH_RGB24) return 3 * ((3 * w) / 2) * h;
        return 2 * w * h;
    endfunction

    // Offer one byte, with an optional gap first, and hold until taken
    task automatic send_byte(input logic [7:0] d, input logic st);
        @(negedge aclk);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(d, st);
        bytes_sent++;
    endtask

    task automatic send_le(input logic [31:0] v, input int unsigned nbytes, input bit mark);
        for (int i = 0; i < nbytes; i++) send_byte(v[8*i +: 8], mark && i == 0);
    endtask

    // Send one file: header, palette chunk when flagged, pixel chunk, data
    task automatic send_tim(input logic [31:0] magic, input bit mark,
                            input logic [31:0] type_word, input int unsigned clut_size,
                            input logic [15:0] w, input logic [15:0] h,
                            input int unsigned pix_bytes);
        send_le(magic, 4, mark);
        send_le(type_word, 4, 1'b0);
        if (type_word[31:3] != 0) begin
            send_le(clut_size, 4, 1'b0);
            send_le($urandom(), 4, 1'b0);
            send_le($urandom(), 4, 1'b0);
            if (clut_size > CLUT_HDR_BYTES)
                repeat (clut_size - CLUT_HDR_BYTES) send_byte(rand_byte(), 1'b0);
        end
        send_le($urandom(), 4, 1'b0);
        send_le($urandom(), 4, 1'b0);
        send_le({h, w}, 4, 1'b0);
        repeat (pix_bytes) send_byte(rand_byte(), 1'b0);
    endtask

    // Result sink: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each result transaction
    always @(posedge aclk) begin : result_monitor
        argb_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.argb = m_tdata[31:0];
            got.col  = m_tdata[43:32];
            got.row  = m_tdata[52:44];
            got.done = m_tuser[0];
            got.err  = err_code_t'(m_tuser[3:1]);
            got.last = m_tlast;
            sb.check_output(got, m_tdata[55:53]);
        end
    end

    initial begin : main_seq
        int unsigned start_bytes;
        int unsigned mode;
        int unsigned clut;
        int unsigned pix;
        int unsigned sel;
        logic [31:0] magic;
        logic [31:0] tw;
        logic [15:0] w;
        logic [15:0] h;
        bit          pal;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full palette with three extra halfwords; first byte carries no start mark
        send_tim(TIM_MAGIC, 1'b0, 32'(DEPTH_IDX8) | PAL_FLAG,
                 CLUT_HDR_BYTES + 2 * TTA_PALETTE_ENTRIES + 6, 2, 2,
                 needed_bytes(DEPTH_IDX8, 2, 2));
        // The other depths
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX4) | PAL_FLAG, CLUT_HDR_BYTES + 32, 1, 2,
                 needed_bytes(DEPTH_IDX4, 1, 2));
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 3, 2, needed_bytes(DEPTH_RGB15, 3, 2));
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB24), 0, 3, 2, needed_bytes(DEPTH_RGB24, 3, 2));
        // Short palette chunk with every flag bit, then a one-byte palette body
        send_tim(TIM_MAGIC, 1'b1, 32'hFFFF_FFF8 | 32'(DEPTH_RGB15), 5, 2, 1,
                 needed_bytes(DEPTH_RGB15, 2, 1));
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB24) | PAL_FLAG, CLUT_HDR_BYTES + 1, 1, 3,
                 needed_bytes(DEPTH_RGB24, 1, 3));
        // Header errors: bad magic, modes past the last depth, missing palette
        send_tim(32'h0000_0011, 1'b1, 32'(DEPTH_RGB15), 0, 1, 1, 2);
        send_tim(32'h1000_0010, 1'b1, 32'(DEPTH_RGB15), 0, 1, 1, 2);
        send_tim(TIM_MAGIC, 1'b1, 32'h0000_0004, 0, 1, 1, 2);
        send_tim(TIM_MAGIC, 1'b1, 32'h0000_0007 | PAL_FLAG, CLUT_HDR_BYTES, 1, 1, 2);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX4), 0, 1, 1, 2);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX8), 0, 1, 1, 2);
        // Oversize images
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX4) | PAL_FLAG, CLUT_HDR_BYTES, 1025, 1, 4);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 16, TTA_MAX_ROWS + 1, 4);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB24), 0, 16'hFFFF, 16'hFFFF, 4);
        // Empty images
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 0, 3, 4);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 4, 0, 4);
        // Trailing bytes after an image, a cut image and a cut header
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX8) | PAL_FLAG, CLUT_HDR_BYTES + 8, 2, 1,
                 needed_bytes(DEPTH_IDX8, 2, 1) + 5);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 4, 4, 7);
        send_le(TIM_MAGIC, 4, 1'b1);
        send_le(32'(DEPTH_RGB15), 2, 1'b0);
        // Largest width and largest height, each cut short after a few bytes
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_IDX4) | PAL_FLAG, CLUT_HDR_BYTES, 1024, 1, 8);
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 1, TTA_MAX_ROWS, 8);

        // Back-pressure: sink holds off while this image streams in
        hold_req = 1'b1;
        send_tim(TIM_MAGIC, 1'b1, 32'(DEPTH_RGB15), 0, 8, 2,
                 needed_bytes(DEPTH_RGB15, 8, 2));

        // Random files, mostly well formed, with some noise between them
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (bytes_sent - start_bytes > RANDOM_BYTES * 3 / 4) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end else begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 24) == 0) begin
                repeat ($urandom_range(1, 10)) send_byte(rand_byte(), $urandom_range(0, 7) == 0);
            end else begin
                magic = TIM_MAGIC;
                if ($urandom_range(0, 99) < 4) magic = magic ^ (32'd1 << $urandom_range(0, 31));
                mode = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
                if (mode < DEPTH_RGB15) pal = ($urandom_range(0, 19) != 0);
                else pal = ($urandom_range(0, 1) == 1);
                tw = pal ? (($urandom() & 32'hFFFF_FFF8) | 32'(mode)) : 32'(mode);
                if (pal && tw[31:3] == 0) tw = tw | PAL_FLAG;
                case ($urandom_range(0, 9))
                    0:       clut = $urandom_range(0, CLUT_HDR_BYTES);
                    1:       clut = CLUT_HDR_BYTES + 1 + 2 * $urandom_range(0, 15);
                    default: clut = CLUT_HDR_BYTES + 2 * $urandom_range(0, 24);
                endcase
                w = $urandom_range(1, 5);
                h = $urandom_range(1, 4);
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    if ($urandom_range(0, 1)) w = 0;
                    else h = 0;
                end else if (sel < 6) begin
                    if ($urandom_range(0, 1)) w = $urandom_range(2800, 65535);
                    else h = $urandom_range(TTA_MAX_ROWS + 1, 65535);
                end
                pix = needed_bytes(mode, w, h);
                if (sel < 6) begin
                    pix = $urandom_range(0, 8);
                end else begin
                    sel = $urandom_range(0, 99);
                    if (sel < 8) pix = $urandom_range(0, pix - 1);
                    else if (sel < 13) pix += $urandom_range(1, 6);
                end
                send_tim(magic, 1'b1, tw, clut, w, h, pix);
            end
        end

        // Drain
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Covered %0d input bytes and %0d results: %0d images finished, %0d errors",
                 sb.bytes_noted, sb.result_count, sb.image_count, sb.error_results);
        if (sb.fail_count == 0) begin
            $display("tim_texture_to_argb_unit regression: pass");
        end else begin
            $display("tim_texture_to_argb_unit regression: fail");
        end
        $finish;
    end

endmodule
